### hw/rtl/f2sf_pkg.sv
package f2sf_pkg;

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } op_e;

  localparam logic [10:0] SF_MAN_MAX  = 11'h7FF;
  localparam logic [3:0]  SF_EXP_MAX  = 4'd15;
  localparam logic [7:0]  BEXP_SAT    = 8'd138;
  localparam logic [7:0]  BEXP_UNITY  = 8'd135;

  typedef struct packed {
    op_e         operation;
    logic [31:0] word_in;
  } req_t;

  typedef struct packed {
    logic [31:0] word_out;
  } rsp_t;

endpackage

### hw/rtl/f2sf_if.sv
interface f2sf_req_if;
  import f2sf_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface f2sf_rsp_if;
  import f2sf_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/float32_to_short_float_codec.sv
// channel | dir | payload
// in_if   | in  | operation, word_in
// out_if  | out | word_out
// One item per cycle if not stalled; result is valid the next cycle.
// Path: input port -> converter -> result register.
// Reset clears the valid flag; payload is not reset.
// A stalled result holds; input is taken while the result slot is free
// or being drained in the same cycle.
module float32_to_short_float_codec
  import f2sf_pkg::*;
(
  input logic         clk_i,
  input logic         rst_ni,
  f2sf_req_if.sink    in_if,
  f2sf_rsp_if.source  out_if
);

  logic valid_q;
  rsp_t data_q;
  rsp_t data_d;

  assign in_if.ready  = !valid_q || out_if.ready;
  assign out_if.valid = valid_q;
  assign out_if.data  = data_q;

  f2sf_conv u_conv (
    .req_i (in_if.data),
    .rsp_o (data_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_if.ready) begin
      valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.ready && in_if.valid) begin
      data_q <= data_d;
    end
  end

endmodule

### hw/rtl/f2sf_conv.sv
module f2sf_conv
  import f2sf_pkg::*;
(
  input  req_t req_i,
  output rsp_t rsp_o
);

  logic        sign;
  logic [7:0]  bexp;
  logic [22:0] frac;
  logic [23:0] sig;
  logic [25:0] d;
  logic [25:0] dn;
  logic [3:0]  e;
  logic [15:0] enc;
  logic [10:0] man;
  logic [3:0]  p;
  logic [3:0]  se;
  logic [7:0]  obexp;
  logic [22:0] ofrac;
  logic [31:0] dec;
  logic [7:0]  sh;

  always_comb begin
    sign = req_i.word_in[31];
    bexp = req_i.word_in[30:23];
    frac = req_i.word_in[22:0];
    sig  = {1'b1, frac};
    sh   = BEXP_UNITY - bexp;
    d    = '0;
    if (bexp >= BEXP_UNITY) begin
      d = {2'b00, sig} << bexp[1:0] - BEXP_UNITY[1:0];
    end else if (bexp != 8'd0 && sh < 8'd26) begin
      d = {2'b00, sig} >> sh[4:0];
    end
    // smallest exponent: offset of the leading one above bit 10
    e = 4'd0;
    for (int i = 11; i < 26; i++) begin
      if (d[i]) e = 4'(i - 10);
    end
    dn = d >> e;
    if (bexp == 8'hFF && frac != '0) begin
      enc = '0;
    end else if (bexp == 8'd0 && frac == '0) begin
      enc = '0;
    end else if (bexp == 8'hFF || bexp >= BEXP_SAT) begin
      enc = {SF_EXP_MAX, sign, SF_MAN_MAX};
    end else begin
      enc = {e, sign, dn[10:0]};
    end

    man = req_i.word_in[10:0];
    se  = req_i.word_in[15:12];
    p   = 4'd0;
    for (int i = 0; i < 11; i++) begin
      if (man[i]) p = 4'(i);
    end
    obexp = 8'(p) + 8'(se) + 8'd112;
    ofrac = 23'({12'd0, man} << (5'd23 - 5'(p)));
    if (man == '0) begin
      dec = {req_i.word_in[11], 31'd0};
    end else begin
      dec = {req_i.word_in[11], obexp, ofrac};
    end

    rsp_o.word_out = (req_i.operation == OP_DECODE) ? dec : {16'd0, enc};
  end

endmodule

### hw/rtl/f2sf_checker.sv
module f2sf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_data_i
);

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i) else $error("ready low with empty output");

  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i) else $error("item lost");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result changed");

endmodule

bind float32_to_short_float_codec f2sf_checker u_f2sf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_data_i  (out_if.data)
);
